### design/gss_pkg.sv
// Shared types and constants for the grid sweep block.
// Used by gss_ctrl, gss_datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package gss_pkg;

  // Grid geometry
  localparam int MAX_DIMS   = 4;
  localparam int VALUE_BITS = 16;
  localparam int SUM_BITS   = VALUE_BITS + 2;
  localparam int DIM_IDX_W  = $clog2(MAX_DIMS);
  localparam int DCNT_W     = 3;

  // Register map
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 3'd4;

  // Range register subfield positions
  localparam int RNG_MIN_LSB  = 0;
  localparam int RNG_MAX_LSB  = 16;
  localparam int RNG_STEP_LSB = 32;
  localparam logic [CFG_DATA_W-1:0] RANGE_RESET = 48'h0001_0000_0000;
  localparam logic [DCNT_W-1:0]     DIMS_RESET  = 3'd1;

  // Stream widths
  localparam int TARGET_W   = 32;
  localparam int OUT_DATA_W = 4 * 16 + TARGET_W;
  localparam int OUT_USER_W = 2;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted input item
    logic update;   // restart or compare-and-advance
    logic emit;     // load the output register
  } gss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free; // output register empty or being drained
  } gss_status_t;

endpackage

### design/gss_ctrl.sv
// Sequencer for the grid sweep: accept, update, emit.
// Depends on gss_pkg for the command and status structs.
`timescale 1ns / 1ps

module gss_ctrl
  import gss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  gss_status_t status,
  output gss_cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/gss_datapath.sv
// Sweep datapath: range registers, current and best point, best value,
// odometer advance and the output register. Depends on gss_pkg.
`timescale 1ns / 1ps

module gss_datapath
  import gss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wen,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [TARGET_W-1:0]    in_target,
  input  logic                   in_restart,
  input  gss_cmd_t               cmd,
  output gss_status_t            status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_DATA_W-1:0]  out_data,
  output logic [OUT_USER_W-1:0]  out_user
);

  typedef logic signed [VALUE_BITS-1:0] val_t;

  // Configuration
  logic [CFG_DATA_W-1:0] range_cfg [MAX_DIMS];
  logic [DCNT_W-1:0]     dims_cfg;

  // Sweep state
  val_t                  cur [MAX_DIMS];
  val_t                  best_pt [MAX_DIMS];
  logic [TARGET_W-1:0]   best_value;
  logic                  best_seen;

  // Latched input item
  logic [TARGET_W-1:0]   target;
  logic                  restart;

  // Derived per-dimension values
  val_t                  dmin [MAX_DIMS];
  val_t                  dmax [MAX_DIMS];
  logic [VALUE_BITS-1:0] dstep [MAX_DIMS];
  logic [MAX_DIMS-1:0]   can_step;
  logic [MAX_DIMS-1:0]   dim_used;
  logic [DCNT_W-1:0]     n_used;
  val_t                  cur_next [MAX_DIMS];
  logic                  carry;
  logic                  take_best;
  logic                  has_next;
  logic [15:0]           res_val [MAX_DIMS];

  // Configuration writes; indices past the map are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_DIMS; d++) range_cfg[d] <= RANGE_RESET;
      dims_cfg <= DIMS_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index) inside
        CFG_RANGE0, CFG_RANGE1, CFG_RANGE2, CFG_RANGE3:
          range_cfg[cfg_index[DIM_IDX_W-1:0]] <= cfg_wdata;
        CFG_DIMS: dims_cfg <= cfg_wdata[DCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Used dimension count clamped to 1..MAX_DIMS
  always_comb begin
    n_used = dims_cfg;
    if (dims_cfg == '0) n_used = DCNT_W'(1);
    if (dims_cfg > DCNT_W'(MAX_DIMS)) n_used = DCNT_W'(MAX_DIMS);
  end

  // Subfields and step test, exact in SUM_BITS
  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      dmin[d]     = range_cfg[d][RNG_MIN_LSB +: VALUE_BITS];
      dmax[d]     = range_cfg[d][RNG_MAX_LSB +: VALUE_BITS];
      dstep[d]    = range_cfg[d][RNG_STEP_LSB +: VALUE_BITS];
      dim_used[d] = (DCNT_W'(d) < n_used);
      can_step[d] = ($signed(SUM_BITS'(cur[d])) + $signed({2'b00, dstep[d]}))
                    <= $signed(SUM_BITS'(dmax[d]));
    end
  end

  // Odometer advance, dimension 0 least significant
  always_comb begin
    carry = 1'b1;
    for (int d = 0; d < MAX_DIMS; d++) begin
      cur_next[d] = cur[d];
      if (carry && dim_used[d]) begin
        if (can_step[d]) begin
          cur_next[d] = val_t'(cur[d] + dstep[d]);
          carry       = 1'b0;
        end else begin
          cur_next[d] = dmin[d];
        end
      end
    end
  end

  assign take_best = !best_seen || ($signed(target) < $signed(best_value));

  // Input latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      target  <= in_target;
      restart <= in_restart;
    end
  end

  // Sweep state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < MAX_DIMS; d++) begin
        cur[d]     <= '0;
        best_pt[d] <= '0;
      end
      best_value <= '0;
      best_seen  <= 1'b0;
    end else if (cmd.update) begin
      if (restart) begin
        for (int d = 0; d < MAX_DIMS; d++) begin
          cur[d]     <= dmin[d];
          best_pt[d] <= dmin[d];
        end
        best_value <= '0;
        best_seen  <= 1'b0;
      end else begin
        if (take_best) begin
          best_value <= target;
          best_seen  <= 1'b1;
          for (int d = 0; d < MAX_DIMS; d++) best_pt[d] <= cur[d];
        end
        for (int d = 0; d < MAX_DIMS; d++) cur[d] <= cur_next[d];
      end
    end
  end

  // Result fields from the updated state
  assign has_next = |(can_step & dim_used);

  always_comb begin
    for (int d = 0; d < MAX_DIMS; d++) begin
      res_val[d] = '0;
      if (dim_used[d]) res_val[d] = 16'(has_next ? cur[d] : best_pt[d]);
    end
  end

  // Output register
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= {best_value, res_val[3], res_val[2], res_val[1], res_val[0]};
      out_user <= {best_seen, has_next};
    end
  end

endmodule

### design/grid_search_sweep_with_argmin_unit.sv
// Top level of the grid sweep with running argmin.
// Instantiates gss_ctrl and gss_datapath; depends on gss_pkg.
`timescale 1ns / 1ps

// Each accepted item passes through the transfer, an update step in which the
// best value is compared and the odometer advances through its carry chain,
// and an emit step that loads the output register. The next item is taken once
// that register is loaded, so the block works on one item at a time; a stalled
// sink holds the sequencer in its emit step. Range and count registers are to be
// written through the cfg port only while no item is in flight; that duty lies
// with the user, as the block has no check for it.

module grid_search_sweep_with_argmin_unit
  import gss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TARGET_W-1:0]   s_tdata,   // [31:0] target_value
  input  logic                  s_tuser,   // [0] restart
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [15:0] value_dim0, [31:16] value_dim1,
                                           // [47:32] value_dim2, [63:48] value_dim3,
                                           // [95:64] best_target
  output logic [OUT_USER_W-1:0] m_tuser    // [0] has_next, [1] best_valid
);

  gss_cmd_t    cmd;
  gss_status_t status;

  gss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gss_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_target  (s_tdata),
    .in_restart (s_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_user   (m_tuser)
  );

  // One item at a time: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in flight");

  // No best recorded means best_target reads zero
  a_best_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1]) |-> (m_tdata[95:64] == '0))
    else $error("best_target nonzero without a recorded best");

  // A fresh result is loaded only from the emit step, never from idle
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result loaded while input side idle");

endmodule

### tb/tb_grid_search_sweep_with_argmin_unit.sv
// Self-checking testbench for the grid sweep with running argmin.
// Directed table then randomized phases, checked against an in-bench predictor.
// Depends on gss_pkg and grid_search_sweep_with_argmin_unit.
`timescale 1ns / 1ps

module tb_grid_search_sweep_with_argmin_unit;
  import gss_pkg::*;

  localparam int NUM_DIR       = 25;
  localparam int NUM_PHASES    = 13;
  localparam int PHASE_ITEMS   = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [0:0] {ROW_WRITE, ROW_ITEM} row_kind_e;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE} sink_mode_e;

  // One directed row: a register write or an input item, with an optional
  // hand-written expectation (exp_data / exp_user laid out as on the port).
  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
    logic                  restart;
    logic [TARGET_W-1:0]   target;
    logic                  typed;
    logic [OUT_DATA_W-1:0] exp_data;
    logic [OUT_USER_W-1:0] exp_user;
  } dir_row_t;

  typedef struct {
    logic [15:0]         dim_val [MAX_DIMS];
    logic                has_next;
    logic [TARGET_W-1:0] best_target;
    logic                best_valid;
  } sweep_res_t;

  // Range words are {step, max, min}, 16 bits each
  localparam dir_row_t DIR_TABLE [0:NUM_DIR-1] = '{
    // after reset: single dim, min = max = 0, so the sweep is always done
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0005, 1'b1, {32'h0000_0005, 64'h0}, 2'b10},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h8000_0000, 1'b1, {32'h8000_0000, 64'h0}, 2'b10},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h7FFF_FFFF, 1'b1, {32'h8000_0000, 64'h0}, 2'b10},
    '{ROW_ITEM,  '0, '0, 1'b1, 32'h1234_5678, 1'b1, {32'h0, 64'h0}, 2'b00},
    // full-scale dim0 with max step, min above max, zero step, negative min
    '{ROW_WRITE, CFG_RANGE0, 48'hFFFF_7FFF_8000, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_RANGE1, 48'h0001_8000_7FFF, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_RANGE2, 48'h0000_0003_0003, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_RANGE3, 48'h0002_0002_FFFE, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_DIMS,   48'h0000_0000_0004, 1'b0, '0, 1'b0, '0, '0},
    // unmapped index must not disturb anything
    '{ROW_WRITE, CFG_SPARE_LO, 48'hFFFF_FFFF_FFFF, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b1, 32'h0, 1'b1,
      {32'h0, 16'hFFFE, 16'h0003, 16'h7FFF, 16'h8000}, 2'b01},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0000, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'hFFFF_FFFF, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0001, 1'b0, '0, '0},
    // count of zero acts as one; range change without a restart
    '{ROW_WRITE, CFG_DIMS,   48'hFFFF_FFFF_FFF8, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_RANGE0, 48'h0003_0004_0000, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0100, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_0080, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'hFFFF_0000, 1'b0, '0, '0},
    // count above the maximum acts as four
    '{ROW_WRITE, CFG_DIMS,   48'h0000_0000_0007, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_WRITE, CFG_SPARE_HI, 48'h0, 1'b0, '0, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b1, 32'hAAAA_5555, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h7FFF_FFFF, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h0001_0000, 1'b0, '0, '0},
    '{ROW_ITEM,  '0, '0, 1'b0, 32'h0000_FFFF, 1'b0, '0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TARGET_W-1:0]   s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;

  // Predictor copy of the registers and sweep state
  logic [CFG_DATA_W-1:0] range_reg [MAX_DIMS];
  logic [DCNT_W-1:0]     dims_reg;
  int                    cur_pt [MAX_DIMS];
  int                    best_pt [MAX_DIMS];
  logic [TARGET_W-1:0]   best_val;
  logic                  best_seen;

  sweep_res_t sweep_expected [$];
  int         err_count = 0;
  int         burst_left = 0;
  bit         hold_off_req = 1'b0;
  bit         hold_off_done = 1'b0;

  grid_search_sweep_with_argmin_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL grid_search_sweep_with_argmin_unit");
    $finish;
  end

  // Range subfields: min and max are signed, step is unsigned
  function automatic int rng_min(input int d);
    return int'($signed(range_reg[d][RNG_MIN_LSB +: VALUE_BITS]));
  endfunction

  function automatic int rng_max(input int d);
    return int'($signed(range_reg[d][RNG_MAX_LSB +: VALUE_BITS]));
  endfunction

  function automatic int rng_step(input int d);
    return int'(range_reg[d][RNG_STEP_LSB +: VALUE_BITS]);
  endfunction

  // Sum kept in 32 bits so a big step never wraps past max
  function automatic bit step_ok(input int d);
    return (cur_pt[d] + rng_step(d)) <= rng_max(d);
  endfunction

  function automatic int dims_used();
    int n;
    n = int'(dims_reg);
    if (n < 1) n = 1;
    if (n > MAX_DIMS) n = MAX_DIMS;
    return n;
  endfunction

  // Update the sweep with one item and return the result it should produce
  function automatic sweep_res_t sweep_step(input logic restart, input logic [TARGET_W-1:0] tgt);
    sweep_res_t res;
    int         n;
    int         d;
    bit         more;
    bit         carry;
    n = dims_used();
    if (restart) begin
      for (d = 0; d < MAX_DIMS; d++) begin
        cur_pt[d]  = rng_min(d);
        best_pt[d] = rng_min(d);
      end
      best_val  = '0;
      best_seen = 1'b0;
    end else begin
      // strictly smaller wins; nothing recorded yet counts as infinity
      if (!best_seen || $signed(tgt) < $signed(best_val)) begin
        best_val  = tgt;
        best_seen = 1'b1;
        best_pt   = cur_pt;
      end
      // odometer advance, dim 0 least significant
      carry = 1'b1;
      for (d = 0; d < n; d++) begin
        if (carry) begin
          if (step_ok(d)) begin
            cur_pt[d] = cur_pt[d] + rng_step(d);
            carry = 1'b0;
          end else begin
            cur_pt[d] = rng_min(d);
          end
        end
      end
    end
    more = 1'b0;
    for (d = 0; d < n; d++)
      if (step_ok(d)) more = 1'b1;
    for (d = 0; d < MAX_DIMS; d++) begin
      if (d >= n) res.dim_val[d] = '0;
      else if (more) res.dim_val[d] = cur_pt[d][15:0];
      else res.dim_val[d] = best_pt[d][15:0];
    end
    res.has_next    = more;
    res.best_target = best_val;
    res.best_valid  = best_seen;
    return res;
  endfunction

  // Register write at the next edge, mirrored into the predictor
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx) inside
      CFG_RANGE0, CFG_RANGE1, CFG_RANGE2, CFG_RANGE3: range_reg[idx[1:0]] = data;
      CFG_DIMS: dims_reg = data[DCNT_W-1:0];
      default: ;
    endcase
  endtask

  // Stop offering items and wait until every expected result has come back
  task automatic drain();
    cfg_wen  <= 1'b0;
    s_tvalid <= 1'b0;
    while (sweep_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item in a bursty pattern; predict once the transfer happens
  task automatic send_item(input logic restart, input logic [TARGET_W-1:0] tgt,
                           input bit typed, input sweep_res_t typed_res);
    int         gap;
    sweep_res_t pred;
    cfg_wen <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= tgt;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    pred = sweep_step(restart, tgt);
    sweep_expected.push_back(typed ? typed_res : pred);
  endtask

  // Sink: segments of always-ready, coin-flip and sparse ready, plus one long hold
  initial begin : sink
    int         seg_len;
    sink_mode_e mode;
    forever begin
      seg_len = $urandom_range(16, 160);
      mode    = sink_mode_e'($urandom_range(0, 2));
      repeat (seg_len) begin
        @(posedge clk);
        if (hold_off_req && !hold_off_done) begin
          hold_off_done = 1'b1;
          m_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          SINK_OPEN: m_tready <= 1'b1;
          SINK_COIN: m_tready <= 1'($urandom_range(0, 1));
          default:   m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin : check
    sweep_res_t want;
    int         d;
    if (!rst && m_tvalid && m_tready) begin
      if (sweep_expected.size() == 0) begin
        $error("unexpected result: tdata %h tuser %h", m_tdata, m_tuser);
        err_count++;
      end else begin
        want = sweep_expected.pop_front();
        for (d = 0; d < MAX_DIMS; d++) begin
          if (m_tdata[16*d +: 16] !== want.dim_val[d]) begin
            $error("value_dim%0d: expected %h, got %h", d, want.dim_val[d], m_tdata[16*d +: 16]);
            err_count++;
          end
        end
        if (m_tdata[95:64] !== want.best_target) begin
          $error("best_target: expected %h, got %h", want.best_target, m_tdata[95:64]);
          err_count++;
        end
        if (m_tuser[0] !== want.has_next) begin
          $error("has_next: expected %b, got %b", want.has_next, m_tuser[0]);
          err_count++;
        end
        if (m_tuser[1] !== want.best_valid) begin
          $error("best_valid: expected %b, got %b", want.best_valid, m_tuser[1]);
          err_count++;
        end
      end
    end
  end

  // Stimulus
  initial begin : stim
    dir_row_t              row;
    sweep_res_t            typed_res;
    sweep_res_t            unused_res;
    logic [CFG_DATA_W-1:0] word;
    logic [TARGET_W-1:0]   tgt;
    logic                  rs;
    int                    r, d, ph, i, sel, mn, mx, st;

    for (d = 0; d < MAX_DIMS; d++) begin
      range_reg[d] = RANGE_RESET;
      cur_pt[d]    = 0;
      best_pt[d]   = 0;
    end
    dims_reg  = DIMS_RESET;
    best_val  = '0;
    best_seen = 1'b0;
    for (d = 0; d < MAX_DIMS; d++) unused_res.dim_val[d] = '0;
    unused_res.has_next    = 1'b0;
    unused_res.best_target = '0;
    unused_res.best_valid  = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (r = 0; r < NUM_DIR; r++) begin
      row = DIR_TABLE[r];
      if (row.kind == ROW_WRITE) begin
        drain();
        write_reg(row.idx, row.wdata);
      end else begin
        for (d = 0; d < MAX_DIMS; d++) typed_res.dim_val[d] = row.exp_data[16*d +: 16];
        typed_res.best_target = row.exp_data[95:64];
        typed_res.has_next    = row.exp_user[0];
        typed_res.best_valid  = row.exp_user[1];
        send_item(row.restart, row.target, row.typed, typed_res);
      end
    end

    // Random phases: new ranges and count while idle, then a stream of items
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      for (d = 0; d < MAX_DIMS; d++) begin
        if (ph == 0 || $urandom_range(0, 3) != 0) begin
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            word = {16'($urandom), $urandom};
          end else if (sel == 1) begin
            word = {($urandom_range(0, 1) ? 16'hFFFF : 16'h0001), 16'h7FFF, 16'h8000};
          end else if (sel == 2) begin
            word = {16'($urandom_range(16'h4000, 16'hFFFF)), 16'($urandom), 16'($urandom)};
          end else begin
            // small grid so sweeps run out often
            mn = int'($urandom_range(0, 40)) - 20;
            mx = mn + int'($urandom_range(0, 10));
            if ($urandom_range(0, 9) == 0) mx = mn - int'($urandom_range(1, 3));
            st = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 4));
            word = {st[15:0], mx[15:0], mn[15:0]};
          end
          write_reg(d[CFG_IDX_W-1:0], word);
        end
      end
      write_reg(CFG_DIMS, {13'($urandom), $urandom, 3'($urandom_range(0, 7))});
      if ($urandom_range(0, 2) == 0)
        write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), {16'($urandom), $urandom});

      for (i = 0; i < PHASE_ITEMS; i++) begin
        // every fourth phase keeps the old point across the range change
        if (i == 0) rs = (ph % 4 != 3);
        else rs = ($urandom_range(0, 39) == 0);
        sel = $urandom_range(0, 7);
        if (sel == 0) tgt = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (sel < 4) tgt = 32'($urandom_range(0, 4000)) - 32'd2000;
        else tgt = $urandom;
        // long sink hold while items keep coming
        if (ph == 3 && i == 30) hold_off_req = 1'b1;
        send_item(rs, tgt, 1'b0, unused_res);
      end
    end

    drain();
    repeat (12) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS grid_search_sweep_with_argmin_unit");
    end else begin
      $display("FAIL grid_search_sweep_with_argmin_unit");
    end
    $finish;
  end

endmodule
